>>> sv/otr_pkg.sv
`default_nettype none
package otr_pkg;

  localparam int unsigned REG_W  = 32;
  localparam int unsigned ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_THRESH  = 2'd0,
    REG_RESTART = 2'd1,
    REG_WINDOW  = 2'd2
  } cfg_reg_e;

  localparam logic [REG_W-1:0] RESTART_RST = 32'd1000;
  localparam logic [REG_W-1:0] WINDOW_RST  = 32'd5000;
  localparam logic [11:0]      THRESH_RST  = 12'hFFF;

  localparam logic [1:0] CNT_ZERO = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_MAX  = 2'd3;

endpackage
`default_nettype wire

>>> sv/otr_in_if.sv
`default_nettype none
interface otr_in_if #(
  parameter int unsigned ADC_BITS  = 12,
  parameter int unsigned TIME_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [ADC_BITS-1:0]  first_sample;
  logic [ADC_BITS-1:0]  confirm_sample;
  logic [TIME_BITS-1:0] now_ms;

  modport source (output valid, first_sample, confirm_sample, now_ms, input ready);
  modport sink   (input valid, first_sample, confirm_sample, now_ms, output ready);
endinterface
`default_nettype wire

>>> sv/otr_out_if.sv
`default_nettype none
interface otr_out_if;
  logic       valid;
  logic       ready;
  logic       pack_enable;
  logic       shutdown;
  logic       overcurrent_event;
  logic [1:0] strikes;

  modport source (output valid, pack_enable, shutdown, overcurrent_event, strikes,
                  input ready);
  modport sink   (input valid, pack_enable, shutdown, overcurrent_event, strikes,
                  output ready);
endinterface
`default_nettype wire

>>> sv/overcurrent_trip_retry_top.sv
// A request is registered first in the input stage, then in the result register;
// one request per cycle is taken while the result side does not stall, and the strike
// state updates combinationally between the input register and the result register.
// Backpressure on the result side stalls both stages; ready follows combinationally.
// Reset (rst_ni low, asynchronous): pipeline empty, no strikes, pack closed,
// shutdown clear, threshold 4095, restart delay 1000 ms, window 5000 ms.
`default_nettype none
module overcurrent_trip_retry_top
  import otr_pkg::*;
#(
  parameter int unsigned ADC_BITS  = 12,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  otr_in_if.sink                 sample_i,
  otr_out_if.source              result_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [REG_W-1:0]  pwdata,
  output logic      [REG_W-1:0]  prdata,
  output logic                   pready
);

  logic [ADC_BITS-1:0] thresh;
  logic [REG_W-1:0]    restart;
  logic [REG_W-1:0]    window;

  otr_in_if #(.ADC_BITS(ADC_BITS), .TIME_BITS(TIME_BITS)) stage_if ();

  otr_cfg_regs #(.ADC_BITS(ADC_BITS)) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .thresh_o  (thresh),
    .restart_o (restart),
    .window_o  (window)
  );

  otr_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .up_i   (sample_i),
    .dn_o   (stage_if.source)
  );

  otr_core #(.ADC_BITS(ADC_BITS), .TIME_BITS(TIME_BITS)) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .thresh_i  (thresh),
    .restart_i (restart),
    .window_i  (window),
    .item_i    (stage_if.sink),
    .res_o     (result_o)
  );

endmodule
`default_nettype wire

>>> sv/otr_cfg_regs.sv
`default_nettype none
module otr_cfg_regs
  import otr_pkg::*;
#(
  parameter int unsigned ADC_BITS = 12
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [REG_W-1:0]    pwdata,
  output logic      [REG_W-1:0]    prdata,
  output logic                     pready,
  output logic      [ADC_BITS-1:0] thresh_o,
  output logic      [REG_W-1:0]    restart_o,
  output logic      [REG_W-1:0]    window_o
);

  logic [ADC_BITS-1:0] thresh_q;
  logic [REG_W-1:0]    restart_q;
  logic [REG_W-1:0]    window_q;
  logic                wr_en;
  cfg_reg_e            sel;

  assign wr_en  = psel & penable & pwrite;
  assign sel    = cfg_reg_e'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= ADC_BITS'(THRESH_RST);
      restart_q <= RESTART_RST;
      window_q  <= WINDOW_RST;
    end else if (wr_en) begin
      unique case (sel)
        REG_THRESH:  thresh_q  <= pwdata[ADC_BITS-1:0];
        REG_RESTART: restart_q <= pwdata;
        REG_WINDOW:  window_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_THRESH:  prdata = REG_W'(thresh_q);
      REG_RESTART: prdata = restart_q;
      REG_WINDOW:  prdata = window_q;
      default:     prdata = '0;
    endcase
  end

  assign thresh_o  = thresh_q;
  assign restart_o = restart_q;
  assign window_o  = window_q;

endmodule
`default_nettype wire

>>> sv/otr_in_stage.sv
`default_nettype none
module otr_in_stage (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  otr_in_if.sink    up_i,
  otr_in_if.source  dn_o
);

  logic valid_q;
  logic take;

  assign up_i.ready = ~valid_q | dn_o.ready;
  assign take       = up_i.valid & up_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_i.ready) begin
      valid_q <= up_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      dn_o.first_sample   <= up_i.first_sample;
      dn_o.confirm_sample <= up_i.confirm_sample;
      dn_o.now_ms         <= up_i.now_ms;
    end
  end

  assign dn_o.valid = valid_q;

endmodule
`default_nettype wire

>>> sv/otr_core.sv
`default_nettype none
module otr_core
  import otr_pkg::*;
#(
  parameter int unsigned ADC_BITS  = 12,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [ADC_BITS-1:0] thresh_i,
  input  wire logic [REG_W-1:0]    restart_i,
  input  wire logic [REG_W-1:0]    window_i,
  otr_in_if.sink                   item_i,
  otr_out_if.source                res_o
);

  localparam int unsigned CMP_W = (TIME_BITS > REG_W) ? TIME_BITS : REG_W;

  logic [1:0]           cnt_q, cnt_d, cnt_trip;
  logic [TIME_BITS-1:0] time_q, time_d, time_trip;
  logic                 pack_q, pack_d;
  logic                 shut_q, shut_d;
  logic                 out_valid_q;
  logic                 trip;
  logic                 take;
  logic [TIME_BITS-1:0] elapsed;
  logic [CMP_W-1:0]     elapsed_w;
  logic                 ge_restart;
  logic                 ge_window;

  assign item_i.ready = ~out_valid_q | res_o.ready;
  assign take         = item_i.valid & item_i.ready;

  assign trip = (item_i.first_sample > thresh_i) && (item_i.confirm_sample > thresh_i);

  // trip handling first; the retry and window checks see the updated strike time
  always_comb begin
    cnt_trip  = cnt_q;
    time_trip = time_q;
    if (trip) begin
      if (cnt_q == CNT_ZERO) begin
        time_trip = item_i.now_ms;
      end
      if (cnt_q != CNT_MAX) begin
        cnt_trip = 2'(cnt_q + 2'd1);
      end
    end
  end

  assign elapsed    = item_i.now_ms - time_trip;
  assign elapsed_w  = CMP_W'(elapsed);
  assign ge_restart = elapsed_w >= CMP_W'(restart_i);
  assign ge_window  = elapsed_w >= CMP_W'(window_i);

  always_comb begin
    cnt_d  = cnt_trip;
    time_d = time_trip;
    pack_d = pack_q & ~trip;
    shut_d = shut_q;
    if (cnt_trip == CNT_ONE && ge_restart) begin
      pack_d = 1'b1;
      if (ge_window) begin
        cnt_d  = CNT_ZERO;
        time_d = '0;
      end
    end
    if (cnt_trip == CNT_TWO && !ge_window) begin
      cnt_d  = CNT_ZERO;
      shut_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CNT_ZERO;
      time_q      <= '0;
      pack_q      <= 1'b1;
      shut_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        cnt_q  <= cnt_d;
        time_q <= time_d;
        pack_q <= pack_d;
        shut_q <= shut_d;
      end
      if (item_i.ready) begin
        out_valid_q <= item_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_o.pack_enable       <= pack_d;
      res_o.shutdown          <= shut_d;
      res_o.overcurrent_event <= trip;
      res_o.strikes           <= cnt_d;
    end
  end

  assign res_o.valid = out_valid_q;

endmodule
`default_nettype wire

>>> tb/overcurrent_trip_retry_top_test.sv
`timescale 1ns / 1ps
module overcurrent_trip_retry_top_test;
  import otr_pkg::*;

  localparam int unsigned IDLE_MAX     = 18;
  localparam int unsigned PHASE_PASSES = 240;
  localparam int unsigned PHASE_COUNT  = 6;
  // index 3: no register behind it, writes must be dropped
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 4'hC;

  typedef struct packed {
    logic       pack_enable;
    logic       shutdown;
    logic       overcurrent_event;
    logic [1:0] strikes;
  } status_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [REG_W-1:0]  pwdata;
  logic [REG_W-1:0]  prdata;
  logic              pready;

  otr_in_if #(.ADC_BITS(12), .TIME_BITS(32)) sample_if ();
  otr_out_if result_if ();

  overcurrent_trip_retry_top #(.ADC_BITS(12), .TIME_BITS(32)) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_if),
    .result_o(result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow configuration and protection state
  logic [11:0] thresh_cfg;
  logic [31:0] restart_cfg;
  logic [31:0] window_cfg;
  logic [1:0]  strike_cnt;
  logic [31:0] strike_t0;
  logic        pack_closed;
  logic        shut_latched;

  status_t     expected_status_q[$];
  logic [31:0] clock_ms;
  int          error_count   = 0;
  int          sender_calm   = 0;
  int          receiver_calm = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] cfg_addr(input cfg_reg_e r);
    return {r, 2'b00};
  endfunction

  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(29, 0) == 0) begin
      calm = $urandom_range(60, 10);
      return 0;
    end
    return $urandom_range(IDLE_MAX, 0);
  endfunction

  function automatic void predict_pass(input logic [11:0] first, input logic [11:0] confirm,
                                       input logic [31:0] now);
    logic    trip;
    logic [31:0] elapsed;
    status_t s;
    trip = (first > thresh_cfg) && (confirm > thresh_cfg);
    if (trip) begin
      pack_closed = 1'b0;
      if (strike_cnt == CNT_ZERO) strike_t0 = now;
      if (strike_cnt != CNT_MAX) strike_cnt = strike_cnt + 2'd1;
    end
    elapsed = now - strike_t0;  // wraps modulo 2^32
    if (strike_cnt == CNT_ONE && elapsed >= restart_cfg) begin
      pack_closed = 1'b1;
      if (elapsed >= window_cfg) begin
        strike_cnt = CNT_ZERO;
        strike_t0  = '0;
      end
    end
    if (strike_cnt == CNT_TWO && elapsed < window_cfg) begin
      strike_cnt   = CNT_ZERO;
      shut_latched = 1'b1;
    end
    s.pack_enable       = pack_closed;
    s.shutdown          = shut_latched;
    s.overcurrent_event = trip;
    s.strikes           = strike_cnt;
    expected_status_q.push_back(s);
  endfunction

  function automatic void report_field(input string name, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    error_count++;
  endfunction

  always @(posedge clk_i) begin : check_status
    status_t got;
    status_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got = {result_if.pack_enable, result_if.shutdown, result_if.overcurrent_event,
             result_if.strikes};
      if (expected_status_q.size() == 0) begin
        $display("%0t: unexpected status, expected none actual %b", $time, got);
        error_count++;
      end else begin
        want = expected_status_q.pop_front();
        if (got.pack_enable !== want.pack_enable)
          report_field("pack_enable", want.pack_enable, got.pack_enable);
        if (got.shutdown !== want.shutdown)
          report_field("shutdown", want.shutdown, got.shutdown);
        if (got.overcurrent_event !== want.overcurrent_event)
          report_field("overcurrent_event", want.overcurrent_event, got.overcurrent_event);
        if (got.strikes !== want.strikes)
          report_field("strikes", want.strikes, got.strikes);
      end
    end
  end

  // status receiver with random backpressure
  initial begin : status_sink
    int   stall;
    logic took;
    result_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(receiver_calm);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      took = 1'b0;
      while (!took) begin
        @(negedge clk_i);
        took = result_if.valid;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_pass(input logic [11:0] first, input logic [11:0] confirm,
                           input logic [31:0] now);
    int   gap;
    logic took;
    gap = draw_wait(sender_calm);
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid          <= 1'b1;
    sample_if.first_sample   <= first;
    sample_if.confirm_sample <= confirm;
    sample_if.now_ms         <= now;
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      if (sample_if.ready) begin
        took = 1'b1;
        predict_pass(first, confirm, now);
      end
      @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    sample_if.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [ADDR_W-1:0] addr, input logic [REG_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == cfg_addr(REG_THRESH)) thresh_cfg = data[11:0];
    else if (addr == cfg_addr(REG_RESTART)) restart_cfg = data;
    else if (addr == cfg_addr(REG_WINDOW)) window_cfg = data;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [31:0] thresh, input logic [31:0] restart,
                              input logic [31:0] window);
    write_cfg(cfg_addr(REG_THRESH), thresh);
    write_cfg(cfg_addr(REG_RESTART), restart);
    write_cfg(cfg_addr(REG_WINDOW), window);
  endtask

  function automatic logic [11:0] over_sample();
    if (thresh_cfg == 12'hFFF) return 12'hFFF;
    return 12'($urandom_range(4095, int'(thresh_cfg) + 1));
  endfunction

  function automatic logic [11:0] under_sample();
    return 12'($urandom_range(int'(thresh_cfg), 0));
  endfunction

  function automatic logic [31:0] pick_delay();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return '1;
      2: return $urandom();
      default: return $urandom_range(3000, 1);
    endcase
  endfunction

  task automatic run_random_passes(input int passes);
    logic [11:0] first;
    logic [11:0] confirm;
    logic [31:0] advance;
    repeat (passes) begin
      case ($urandom_range(9, 0))
        0, 1, 2, 3: advance = $urandom_range(64, 0);
        4, 5, 6: advance = $urandom_range(2048, 0);
        7, 8: advance = $urandom_range(8192, 0);
        default: advance = $urandom();
      endcase
      clock_ms += advance;
      case ($urandom_range(9, 0))
        0, 1, 2: begin first = over_sample(); confirm = over_sample(); end
        3: begin first = over_sample(); confirm = under_sample(); end
        4: begin first = under_sample(); confirm = over_sample(); end
        5: begin first = thresh_cfg; confirm = over_sample(); end
        default: begin
          first   = 12'($urandom_range(4095, 0));
          confirm = 12'($urandom_range(4095, 0));
        end
      endcase
      // a second strike past the window latches the pack open for good;
      // that is saved for the last test
      if (strike_cnt == CNT_ONE && (clock_ms - strike_t0) >= window_cfg)
        first = under_sample();
      send_pass(first, confirm, clock_ms);
    end
  endtask

  task automatic test_reset_defaults();
    send_pass(12'hFFF, 12'hFFF, 32'd0);
    send_pass(12'h000, 12'h000, 32'd5);
    send_pass(12'hFFF, 12'h000, 32'd10);
  endtask

  task automatic test_trip_qualify();
    wait_idle();
    // upper bits of the threshold word are dropped: 0x7D0 = 2000
    apply_config(32'hABCD_E7D0, 32'd100, 32'd500);
    write_cfg(UNMAPPED_ADDR, 32'd0);
    send_pass(12'd2001, 12'd2000, 32'd100);
    send_pass(12'd2000, 12'd2001, 32'd110);
    send_pass(12'd2000, 12'd2000, 32'd120);
  endtask

  task automatic test_retry_and_clear();
    send_pass(12'hFFF, 12'd2001, 32'd1000);
    send_pass(12'h000, 12'h000, 32'd1099);
    send_pass(12'h000, 12'h000, 32'd1100);
    send_pass(12'h000, 12'h000, 32'd1499);
    send_pass(12'h000, 12'h000, 32'd1500);
  endtask

  task automatic test_zero_delays_and_shutdown();
    wait_idle();
    write_cfg(cfg_addr(REG_RESTART), 32'd0);
    write_cfg(cfg_addr(REG_WINDOW), 32'd0);
    send_pass(12'hFFF, 12'hFFF, 32'd2000);  // recloses and clears in the same pass
    wait_idle();
    write_cfg(cfg_addr(REG_WINDOW), 32'd1000);
    send_pass(12'hFFF, 12'hFFF, 32'd3000);
    send_pass(12'hFFF, 12'hFFF, 32'd3010);  // second strike inside window
    send_pass(12'h000, 12'h000, 32'd3020);
  endtask

  task automatic test_extreme_config();
    wait_idle();
    apply_config(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pass(12'h000, 12'h000, 32'd0);
    send_pass(12'h001, 12'h001, 32'd5);
    send_pass(12'h000, 12'h000, 32'd4);  // elapsed wraps to the maximum
    send_pass(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    send_pass(12'h000, 12'h000, 32'hFFFF_FFFE);
  endtask

  task automatic test_random_traffic();
    logic [31:0] thresh;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_idle();
      thresh = $urandom();
      case ($urandom_range(4, 0))
        0: thresh[11:0] = 12'd0;
        1: thresh[11:0] = 12'hFFE;
        default: thresh[11:0] = 12'($urandom_range(3500, 200));
      endcase
      if (phase == 0) apply_config(32'd0, 32'd0, 32'hFFFF_FFFF);
      else if (phase == 1) apply_config(thresh, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      else apply_config(thresh, pick_delay(), pick_delay());
      if (phase % 2 == 1) clock_ms = 32'hFFFF_F000 + $urandom_range(4095, 0);
      else clock_ms = $urandom();
      run_random_passes(PHASE_PASSES);
    end
  endtask

  task automatic test_latched_open();
    wait_idle();
    apply_config(32'd2000, 32'd1000, 32'd500);
    if (strike_cnt == CNT_ONE) send_pass(12'h000, 12'h000, strike_t0 + 32'd1000);
    // restart longer than window: the single strike outlives the window
    send_pass(12'hFFF, 12'hFFF, 32'hFFFF_FF00);
    send_pass(12'h000, 12'h000, 32'h0000_0100);
    send_pass(12'hFFF, 12'hFFF, 32'h0000_0200);
    send_pass(12'hFFF, 12'hFFF, 32'h0000_0210);
    send_pass(12'hFFF, 12'hFFF, 32'h0000_0220);
    send_pass(12'h000, 12'h000, 32'h1000_0000);
    clock_ms = 32'h1000_0000;
    run_random_passes(20);
  endtask

  initial begin
    rst_ni                   <= 1'b0;
    sample_if.valid          <= 1'b0;
    sample_if.first_sample   <= '0;
    sample_if.confirm_sample <= '0;
    sample_if.now_ms         <= '0;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    thresh_cfg   = THRESH_RST;
    restart_cfg  = RESTART_RST;
    window_cfg   = WINDOW_RST;
    strike_cnt   = CNT_ZERO;
    strike_t0    = '0;
    pack_closed  = 1'b1;
    shut_latched = 1'b0;
    clock_ms     = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_trip_qualify();
    test_retry_and_clear();
    test_zero_delays_and_shutdown();
    test_extreme_config();
    test_random_traffic();
    test_latched_open();

    wait_idle();
    repeat (6) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
